@@ design/hmd_pkg.sv @@
`default_nettype none
package hmd_pkg;

    localparam int HMD_COUNT_BITS = 32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [4:0] LEN_PREFIX_LEN = 5'd16;
    localparam logic [4:0] CHUNKED_LEN    = 5'd26;
    localparam logic [4:0] POS_FAIL       = 5'd31;

    localparam logic [8*16-1:0] LEN_PREFIX  = "Content-Length: ";
    localparam logic [8*26-1:0] CHUNKED_HDR = "Transfer-Encoding: chunked";

    localparam logic [2:0] KIND_START = 3'd0;
    localparam logic [2:0] KIND_HDR   = 3'd1;
    localparam logic [2:0] KIND_HEND  = 3'd2;
    localparam logic [2:0] KIND_FRAME = 3'd3;
    localparam logic [2:0] KIND_BODY  = 3'd4;
    localparam logic [2:0] KIND_DISC  = 3'd5;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_CRLF     = 3'd1;
    localparam logic [2:0] ERR_COLON    = 3'd2;
    localparam logic [2:0] ERR_LENGTH   = 3'd3;
    localparam logic [2:0] ERR_CSIZE    = 3'd4;
    localparam logic [2:0] ERR_CTRAIL   = 3'd5;

    typedef enum logic [2:0] {
        PH_START,
        PH_HEADER,
        PH_BODY,
        PH_CSIZE,
        PH_CDATA,
        PH_CTRAIL,
        PH_FINAL
    } phase_t;

    typedef enum logic [1:0] {
        COL_NONE,
        COL_JUST,
        COL_GOOD,
        COL_BAD
    } colon_t;

    typedef struct packed {
        logic [2:0] byte_kind;
        logic [7:0] data_out;
        logic       line_end;
        logic       message_done;
        logic [2:0] error_code;
    } result_t;

    function automatic logic [7:0] len_char(logic [3:0] p);
        logic [6:0] base;
        base = {~p, 3'b000};
        return LEN_PREFIX[base +: 8];
    endfunction

    function automatic logic [7:0] chk_char(logic [4:0] p);
        logic [7:0] base;
        base = {5'd25 - p, 3'b000};
        return CHUNKED_HDR[base +: 8];
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [3:0] v;
        if (is_digit(c)) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ design/hmd_core.sv @@
`default_nettype none
module hmd_core #(
    parameter int COUNT_BITS = hmd_pkg::HMD_COUNT_BITS
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire logic [7:0]      rx_byte,
    output hmd_pkg::result_t     result
);
    import hmd_pkg::*;

    localparam int CB = COUNT_BITS;

    typedef struct packed {
        phase_t        phase;
        logic          pending_cr;
        logic          line_nonempty;
        colon_t        colon;
        logic [4:0]    lpos;
        logic [4:0]    cpos;
        logic          lhs;
        logic          lbad;
        logic          chunked;
        logic [CB-1:0] acc;
        logic [CB-1:0] rem;
    } st_t;

    st_t        st_reg, st_next;
    logic [2:0] sticky_reg, sticky_next;
    logic [2:0] kind;
    logic       le;
    logic       done;
    logic [2:0] err;
    logic [CB-1:0] rem_dec;
    logic [CB-1:0] hdr_len;

    function automatic st_t clear_line(st_t s);
        s.pending_cr    = 1'b0;
        s.line_nonempty = 1'b0;
        s.colon         = COL_NONE;
        s.lpos          = '0;
        s.cpos          = '0;
        return s;
    endfunction

    function automatic st_t new_msg(st_t s);
        st_t r;
        r = clear_line(s);
        r.phase   = PH_START;
        r.lhs     = 1'b0;
        r.lbad    = 1'b0;
        r.chunked = 1'b0;
        r.acc     = '0;
        r.rem     = '0;
        return r;
    endfunction

    function automatic st_t hdr_content(st_t s, logic [7:0] c);
        logic [CB+3:0] wide;
        logic [CB+3:0] prod;
        wide = {4'b0000, s.acc};
        prod = (wide << 3) + (wide << 1) + {{CB{1'b0}}, c[3:0]};
        s.line_nonempty = 1'b1;
        if (s.colon == COL_NONE && c == CH_COLON) begin
            s.colon = COL_JUST;
        end else if (s.colon == COL_JUST) begin
            s.colon = (c == CH_SPACE) ? COL_GOOD : COL_BAD;
        end
        if (s.lpos < LEN_PREFIX_LEN) begin
            s.lpos = (c == len_char(s.lpos[3:0])) ? s.lpos + 5'd1 : POS_FAIL;
        end else if (s.lpos == LEN_PREFIX_LEN && !s.lhs && !s.lbad) begin
            if (!is_digit(c) || (|prod[CB+3:CB])) begin
                s.lbad = 1'b1;
            end else begin
                s.acc = prod[CB-1:0];
            end
        end
        if (s.cpos < CHUNKED_LEN) begin
            s.cpos = (c == chk_char(s.cpos)) ? s.cpos + 5'd1 : POS_FAIL;
        end else begin
            s.cpos = POS_FAIL;
        end
        return s;
    endfunction

    function automatic st_t size_content(st_t s, logic [7:0] c);
        if (!s.lbad) begin
            if (!is_hex(c) || (|s.acc[CB-1:CB-4])) begin
                s.lbad = 1'b1;
            end else begin
                s.acc = {s.acc[CB-5:0], hex_val(c)};
            end
        end
        return s;
    endfunction

    assign rem_dec = (st_reg.rem != '0) ? st_reg.rem - {{(CB-1){1'b0}}, 1'b1} : st_reg.rem;
    assign hdr_len = st_reg.lhs ? st_reg.acc : '0;

    // outputs of one step
    always_comb begin
        kind = KIND_DISC;
        le   = 1'b0;
        done = 1'b0;
        err  = ERR_NONE;
        if (sticky_reg == ERR_NONE) begin
            unique case (st_reg.phase)
                PH_HEADER: begin
                    if (rx_byte == CH_LF) begin
                        kind = st_reg.line_nonempty ? KIND_HDR : KIND_HEND;
                        if (!st_reg.pending_cr) begin
                            err = ERR_CRLF;
                        end else if (st_reg.line_nonempty) begin
                            if (st_reg.colon != COL_GOOD) begin
                                err = ERR_COLON;
                            end else begin
                                le = 1'b1;
                            end
                        end else if (st_reg.lhs && st_reg.lbad) begin
                            err = ERR_LENGTH;
                        end else begin
                            le = 1'b1;
                            done = (st_reg.lhs || !st_reg.chunked) && (hdr_len == '0);
                        end
                    end else begin
                        kind = (st_reg.line_nonempty || st_reg.pending_cr || rx_byte != CH_CR)
                               ? KIND_HDR : KIND_HEND;
                    end
                end
                PH_BODY, PH_CDATA: begin
                    kind = KIND_BODY;
                    done = (st_reg.phase == PH_BODY) && (rem_dec == '0);
                end
                PH_CSIZE: begin
                    kind = KIND_FRAME;
                    if (rx_byte == CH_LF) begin
                        if (!st_reg.pending_cr) begin
                            err = ERR_CRLF;
                        end else if (st_reg.lbad) begin
                            err = ERR_CSIZE;
                        end
                    end
                end
                PH_CTRAIL, PH_FINAL: begin
                    kind = KIND_FRAME;
                    if (!st_reg.pending_cr) begin
                        if (rx_byte != CH_CR) begin
                            err = ERR_CTRAIL;
                        end
                    end else if (rx_byte == CH_LF) begin
                        done = (st_reg.phase == PH_FINAL);
                    end else begin
                        err = ERR_CTRAIL;
                    end
                end
                default: begin
                    kind = KIND_START;
                    if (rx_byte == CH_LF) begin
                        if (!st_reg.pending_cr) begin
                            err = ERR_CRLF;
                        end else begin
                            le = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // next state
    always_comb begin
        st_next     = st_reg;
        sticky_next = sticky_reg;
        if (sticky_reg == ERR_NONE) begin
            unique case (st_reg.phase)
                PH_HEADER: begin
                    if (rx_byte == CH_LF) begin
                        if (st_reg.pending_cr && st_reg.line_nonempty &&
                            st_reg.colon == COL_GOOD) begin
                            if (st_reg.lpos == LEN_PREFIX_LEN) begin
                                st_next.lhs = 1'b1;
                            end
                            if (st_reg.cpos == CHUNKED_LEN) begin
                                st_next.chunked = 1'b1;
                            end
                            st_next = clear_line(st_next);
                        end else if (st_reg.pending_cr && !st_reg.line_nonempty) begin
                            st_next = clear_line(st_next);
                            if (!st_reg.lhs && st_reg.chunked) begin
                                st_next.phase = PH_CSIZE;
                                st_next.acc   = '0;
                                st_next.lbad  = 1'b0;
                            end else if (hdr_len == '0) begin
                                st_next = new_msg(st_next);
                            end else begin
                                st_next.rem   = hdr_len;
                                st_next.phase = PH_BODY;
                            end
                        end
                    end else begin
                        if (st_reg.pending_cr) begin
                            st_next = hdr_content(st_next, CH_CR);
                        end
                        if (rx_byte == CH_CR) begin
                            st_next.pending_cr = 1'b1;
                        end else begin
                            st_next = hdr_content(st_next, rx_byte);
                            st_next.pending_cr = 1'b0;
                        end
                    end
                end
                PH_BODY, PH_CDATA: begin
                    st_next.rem = rem_dec;
                    if (rem_dec == '0) begin
                        if (st_reg.phase == PH_BODY) begin
                            st_next = new_msg(st_next);
                        end else begin
                            st_next.phase      = PH_CTRAIL;
                            st_next.pending_cr = 1'b0;
                        end
                    end
                end
                PH_CSIZE: begin
                    if (rx_byte == CH_LF) begin
                        st_next.pending_cr = 1'b0;
                        if (st_reg.acc == '0) begin
                            st_next.phase = PH_FINAL;
                        end else begin
                            st_next.rem   = st_reg.acc;
                            st_next.phase = PH_CDATA;
                        end
                    end else begin
                        if (st_reg.pending_cr) begin
                            st_next = size_content(st_next, CH_CR);
                        end
                        if (rx_byte == CH_CR) begin
                            st_next.pending_cr = 1'b1;
                        end else begin
                            st_next = size_content(st_next, rx_byte);
                            st_next.pending_cr = 1'b0;
                        end
                    end
                end
                PH_CTRAIL, PH_FINAL: begin
                    if (!st_reg.pending_cr) begin
                        st_next.pending_cr = 1'b1;
                    end else begin
                        st_next.pending_cr = 1'b0;
                        if (st_reg.phase == PH_CTRAIL) begin
                            st_next.phase = PH_CSIZE;
                            st_next.acc   = '0;
                            st_next.lbad  = 1'b0;
                        end else begin
                            st_next = new_msg(st_next);
                        end
                    end
                end
                default: begin
                    st_next.phase = PH_START;
                    if (rx_byte == CH_LF) begin
                        st_next.phase = PH_HEADER;
                        st_next = clear_line(st_next);
                    end else begin
                        st_next.pending_cr = (rx_byte == CH_CR);
                    end
                end
            endcase
            if (err != ERR_NONE) begin
                sticky_next = err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= new_msg('0);
            sticky_reg <= ERR_NONE;
        end else if (step) begin
            st_reg     <= st_next;
            sticky_reg <= sticky_next;
        end
    end

    assign result.byte_kind    = kind;
    assign result.data_out     = rx_byte;
    assign result.line_end     = le;
    assign result.message_done = done;
    assign result.error_code   = (sticky_reg != ERR_NONE) ? sticky_reg : err;

endmodule
`default_nettype wire

@@ design/http_message_deframer.sv @@
// path: the input word waits in the input register, then is loaded into the result register on a step
// throughput: one word per cycle while the output is not stalled, through the combinational parse step between
//   the input register and the result register
// reset: aresetn synchronous, active low; clears the parse state and the
//   sticky error, no clearing pass, ready again on the first cycle after reset
`default_nettype none
module http_message_deframer #(
    parameter int COUNT_BITS = hmd_pkg::HMD_COUNT_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // data_out, line_end, error_code, zero fill
    output logic [2:0]       m_tuser,   // byte_kind
    output logic             m_tlast    // message_done
);
    import hmd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    core_result;
    logic       advance;
    logic       step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    hmd_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_data_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (step) begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.error_code, out_reg.line_end, out_reg.data_out};
    assign m_tuser  = out_reg.byte_kind;
    assign m_tlast  = out_reg.message_done;

    // a word raising or carrying an error never closes a line or a message
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[11:9] != ERR_NONE) |-> (!m_tdata[8] && !m_tlast))
        else $error("error word marked as line end or message end");

    // discarded words appear only under an error
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_DISC) |-> (m_tdata[11:9] != ERR_NONE))
        else $error("discarded word without error code");

    // the byte passes through the parse step unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (m_tdata[7:0] == $past(in_data_reg)))
        else $error("data byte altered");

    // message end only on body or framing words, or the header end line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
            (m_tuser == KIND_BODY || m_tuser == KIND_FRAME || m_tuser == KIND_HEND))
        else $error("message end on wrong word kind");

endmodule
`default_nettype wire
